@@ rtl/bts_pkg.sv @@
// ---------------------------------------------------------------------------
// bts_pkg
// Shared types and codes for the block trigger scheduler.
// ---------------------------------------------------------------------------
package bts_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH_AUD   = 2'd0,
        REQ_PUSH_SCHED = 2'd1,
        REQ_TICK       = 2'd2,
        REQ_CLEAR      = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AUD_RD,
        ST_AUD_USE,
        ST_SCH_RD,
        ST_SCH_USE,
        ST_SORT,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  item_event;
        logic [63:0] press_time_us;
        logic [62:0] due_sample;
        logic [31:0] item_generation;
        logic [63:0] time_now_us;
        logic [31:0] active_generation;
    } t_in_word;

    typedef struct packed {
        logic        has_trigger;
        logic [7:0]  trigger_event;
        logic [5:0]  trigger_offset;
        logic [62:0] fired_position;
        logic        is_audition;
        logic        last;
        logic [31:0] latency_last_us;
        logic [31:0] latency_worst_us;
        logic [31:0] latency_count;
    } t_out_word;

endpackage

@@ rtl/bts_if.sv @@
// ---------------------------------------------------------------------------
// bts_if
// Valid/ready channel carrying one word of a given type.
// ---------------------------------------------------------------------------
interface bts_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bts_sort.sv @@
// ---------------------------------------------------------------------------
// bts_sort
// Collect buffer with an insertion stage: each entry is placed in offset order
// on arrival, one compare row per entry, so the order is stable.
// ---------------------------------------------------------------------------
module bts_sort
    import bts_pkg::*;
#(
    parameter int MAX_TRIGGERS = 16
) (
    input  logic       i_clk,
    input  logic       i_clr,
    input  logic       i_ins,
    input  logic [7:0] i_event,
    input  logic [5:0] i_offset,
    input  logic       i_aud,
    input  logic [($clog2(MAX_TRIGGERS) > 0 ? $clog2(MAX_TRIGGERS) : 1)-1:0] i_rd_idx,
    output logic [7:0] o_event,
    output logic [5:0] o_offset,
    output logic       o_aud
);
    localparam int CW = $clog2(MAX_TRIGGERS+1);
    logic [7:0] r_ev  [MAX_TRIGGERS];
    logic [5:0] r_off [MAX_TRIGGERS];
    logic       r_au  [MAX_TRIGGERS];
    logic [CW-1:0] r_cnt;
    logic [MAX_TRIGGERS-1:0] w_gt;
    logic [MAX_TRIGGERS-1:0] w_shift;

    always_comb begin
        for (int k = 0; k < MAX_TRIGGERS; k++) begin
            w_gt[k] = (CW'(k) < r_cnt) && (r_off[k] > i_offset);
        end
    end

    // Slot k takes the entry below it when that entry also has a larger offset.
    assign w_shift = w_gt << 1;

    // Entries with a larger offset move up one place; the new word lands in
    // the first such slot, or at the end.
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_cnt <= '0;
        end else if (i_ins) begin
            r_cnt <= r_cnt + 1'b1;
            for (int k = 0; k < MAX_TRIGGERS; k++) begin
                if (w_gt[k] || CW'(k) == r_cnt) begin
                    if (w_shift[k]) begin
                        r_ev[k] <= r_ev[k-1]; r_off[k] <= r_off[k-1]; r_au[k] <= r_au[k-1];
                    end else begin
                        r_ev[k] <= i_event; r_off[k] <= i_offset; r_au[k] <= i_aud;
                    end
                end
            end
        end
    end

    assign o_event  = r_ev[i_rd_idx];
    assign o_offset = r_off[i_rd_idx];
    assign o_aud    = r_au[i_rd_idx];
endmodule

@@ rtl/block_trigger_scheduler.sv @@
// ---------------------------------------------------------------------------
// block_trigger_scheduler
// Audition and scheduled-trigger queues drained once per audio block tick.
// ---------------------------------------------------------------------------
// Pushes and clears update the queues as they are accepted. A tick reads each
// queue entry from the synchronous queue memories in a read state and then a
// use state, then emits one result word per cycle while the result port is ready.
// The audition drain stops at the result cap or an empty queue; the scheduled
// drain stops at the cap, an empty queue or an entry not yet due. A stall on
// the result port holds the emit, and the next request is taken once the final
// word has gone. The registered read port is why each entry takes both states.
module block_trigger_scheduler
    import bts_pkg::*;
#(
    parameter int BLOCK_FRAMES   = 64,
    parameter int MAX_TRIGGERS   = 16,
    parameter int AUDITION_DEPTH = 16,
    parameter int SCHEDULE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bts_if.sink   i_req,
    bts_if.source o_res
);
    localparam int AW = $clog2(AUDITION_DEPTH);
    localparam int SW = $clog2(SCHEDULE_DEPTH);
    localparam int IW = $clog2(MAX_TRIGGERS) > 0 ? $clog2(MAX_TRIGGERS) : 1;
    localparam int CW = $clog2(MAX_TRIGGERS+1);

    logic [7:0]  r_aev [AUDITION_DEPTH];
    logic [63:0] r_apr [AUDITION_DEPTH];
    logic [7:0]  r_sev [SCHEDULE_DEPTH];
    logic [62:0] r_sdu [SCHEDULE_DEPTH];
    logic [31:0] r_sgn [SCHEDULE_DEPTH];
    logic [7:0]  r_aev_q, r_sev_q;
    logic [63:0] r_apr_q;
    logic [62:0] r_sdu_q;
    logic [31:0] r_sgn_q;

    logic [AW:0] r_ah, r_at, n_ah;
    logic [SW:0] r_sh, r_st, n_sh;
    logic [56:0] r_bc, n_bc;
    logic [62:0] r_bs, n_bs;
    logic [31:0] r_ll, r_wl, r_lc, n_ll, n_wl, n_lc;
    logic [63:0] r_now;
    logic [31:0] r_live;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_oi, n_oi;
    t_state r_st_q, n_st;
    t_in_word w_in;
    logic w_acc, w_aud_full, w_sch_full, w_aud_empty, w_sch_empty;
    logic w_ins, w_clr_sort, w_wr_a, w_wr_s;
    logic [7:0] w_iev; logic [5:0] w_ioff; logic w_iau;
    logic [7:0] s_ev; logic [5:0] s_off; logic s_au;
    logic [62:0] w_start;
    logic [63:0] w_end, w_lat;
    logic [AW-1:0] w_ard; logic [SW-1:0] w_srd;
    t_out_word r_out, n_out;
    logic r_ov, n_ov;

    assign w_in = i_req.data;
    assign w_acc = i_req.valid && i_req.ready;
    assign w_aud_full  = (r_at[AW] != r_ah[AW]) && (r_at[AW-1:0] == r_ah[AW-1:0]);
    assign w_sch_full  = (r_st[SW] != r_sh[SW]) && (r_st[SW-1:0] == r_sh[SW-1:0]);
    assign w_aud_empty = (r_at == r_ah);
    assign w_sch_empty = (r_st == r_sh);
    // The block start is kept as a running sum, restarted when the count wraps.
    assign w_start = r_bs;
    assign w_end   = {1'b0, w_start} + 64'(BLOCK_FRAMES);
    assign w_lat   = r_now - r_apr_q;
    assign w_wr_a = w_acc && t_req'(w_in.req_type) == REQ_PUSH_AUD && !w_aud_full;
    assign w_wr_s = w_acc && t_req'(w_in.req_type) == REQ_PUSH_SCHED && !w_sch_full;
    assign w_ard = n_ah[AW-1:0];
    assign w_srd = n_sh[SW-1:0];

    // Queue memories: one write port for pushes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_aev[r_at[AW-1:0]] <= w_in.item_event;
            r_apr[r_at[AW-1:0]] <= w_in.press_time_us;
        end
        r_aev_q <= r_aev[w_ard];
        r_apr_q <= r_apr[w_ard];
    end
    always_ff @(posedge i_clk) begin
        if (w_wr_s) begin
            r_sev[r_st[SW-1:0]] <= w_in.item_event;
            r_sdu[r_st[SW-1:0]] <= w_in.due_sample;
            r_sgn[r_st[SW-1:0]] <= w_in.item_generation;
        end
        r_sev_q <= r_sev[w_srd];
        r_sdu_q <= r_sdu[w_srd];
        r_sgn_q <= r_sgn[w_srd];
    end

    bts_sort #(.MAX_TRIGGERS(MAX_TRIGGERS)) u_sort (
        .i_clk(i_clk), .i_clr(w_clr_sort), .i_ins(w_ins), .i_event(w_iev),
        .i_offset(w_ioff), .i_aud(w_iau), .i_rd_idx(r_oi),
        .o_event(s_ev), .o_offset(s_off), .o_aud(s_au)
    );

    assign i_req.ready = (r_st_q == ST_IDLE) && !r_ov;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        n_st = r_st_q; n_ah = r_ah; n_sh = r_sh; n_bc = r_bc; n_bs = r_bs;
        n_ll = r_ll; n_wl = r_wl; n_lc = r_lc; n_cnt = r_cnt; n_oi = r_oi;
        n_ov = r_ov && !o_res.ready; n_out = r_out;
        w_ins = 1'b0; w_clr_sort = 1'b0; w_iev = r_aev_q; w_ioff = '0; w_iau = 1'b1;
        case (r_st_q)
            ST_IDLE: begin
                if (w_acc && t_req'(w_in.req_type) == REQ_TICK) begin
                    w_clr_sort = 1'b1; n_cnt = '0; n_st = ST_AUD_RD;
                end
            end
            ST_AUD_RD: begin
                if (r_cnt == CW'(MAX_TRIGGERS)) n_st = ST_SORT;
                else if (w_aud_empty) n_st = ST_SCH_RD;
                else n_st = ST_AUD_USE;
            end
            ST_AUD_USE: begin
                if (r_apr_q != '0) begin
                    n_ll = (r_now > r_apr_q) ? w_lat[31:0] : '0;
                    if (n_ll > r_wl) n_wl = n_ll;
                    n_lc = r_lc + 1'b1;
                end
                w_ins = 1'b1; n_cnt = r_cnt + 1'b1;
                n_ah = r_ah + 1'b1; n_st = ST_AUD_RD;
            end
            ST_SCH_RD: begin
                if (r_cnt == CW'(MAX_TRIGGERS) || w_sch_empty) n_st = ST_SORT;
                else n_st = ST_SCH_USE;
            end
            ST_SCH_USE: begin
                if ({1'b0, r_sdu_q} >= w_end) n_st = ST_SORT;
                else begin
                    n_sh = r_sh + 1'b1; n_st = ST_SCH_RD;
                    if (r_sgn_q == r_live) begin
                        w_ins = 1'b1; n_cnt = r_cnt + 1'b1; w_iev = r_sev_q; w_iau = 1'b0;
                        w_ioff = (r_sdu_q > w_start) ? 6'(r_sdu_q - w_start) : '0;
                    end
                end
            end
            ST_SORT: begin
                n_oi = '0;
                n_st = (r_cnt == '0) ? ST_EMPTY : ST_EMIT;
            end
            ST_EMIT: begin
                if (!n_ov) begin
                    n_ov = 1'b1;
                    n_out = '{1'b1, s_ev, s_off, w_start + 63'(s_off), s_au,
                              (CW'(r_oi) == r_cnt - 1'b1), r_ll, r_wl, r_lc};
                    if (CW'(r_oi) == r_cnt - 1'b1) begin
                        n_bc = r_bc + 1'b1; n_st = ST_IDLE;
                        n_bs = (n_bc == '0) ? '0 : r_bs + 63'(BLOCK_FRAMES);
                    end else n_oi = r_oi + 1'b1;
                end
            end
            ST_EMPTY: begin
                if (!n_ov) begin
                    n_ov = 1'b1;
                    n_out = '{1'b0, 8'd0, 6'd0, 63'd0, 1'b0, 1'b1, r_ll, r_wl, r_lc};
                    n_bc = r_bc + 1'b1; n_st = ST_IDLE;
                    n_bs = (n_bc == '0) ? '0 : r_bs + 63'(BLOCK_FRAMES);
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_q <= ST_IDLE; r_ah <= '0; r_at <= '0; r_sh <= '0; r_st <= '0;
            r_bc <= '0; r_bs <= '0; r_ll <= '0; r_wl <= '0; r_lc <= '0; r_cnt <= '0;
            r_oi <= '0; r_ov <= 1'b0;
        end else begin
            r_st_q <= n_st; r_ah <= n_ah; r_sh <= n_sh; r_bc <= n_bc; r_bs <= n_bs;
            r_ll <= n_ll; r_wl <= n_wl; r_lc <= n_lc; r_cnt <= n_cnt;
            r_oi <= n_oi; r_ov <= n_ov;
            if (w_wr_a) r_at <= r_at + 1'b1;
            if (w_wr_s) r_st <= r_st + 1'b1;
            if (w_acc && t_req'(w_in.req_type) == REQ_CLEAR) begin
                r_ah <= '0; r_at <= '0; r_sh <= '0; r_st <= '0;
                r_bc <= '0; r_bs <= '0; r_ll <= '0; r_wl <= '0; r_lc <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_acc) begin
            r_now <= w_in.time_now_us; r_live <= w_in.active_generation;
        end
    end
endmodule
